FILE: sv/pal_pkg.sv
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types and codes of the positional address list.
// ----------------------------------------------------------------------------
package pal_pkg;

   // fixed field widths
   localparam int CMD_W    = 2;
   localparam int POS_W    = 6;
   localparam int COUNT_W  = 7;
   localparam int BSIZE_W  = 16;
   localparam int STATUS_W = 2;

   // number of list entries, tied to the position and count field widths
   localparam int LIST_DEPTH = 64;

   // reset value of the block size register
   localparam logic [BSIZE_W-1:0] BSIZE_RESET = 16'd16;

   // request codes
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_PUT
   } state_type;

endpackage

FILE: sv/pal_ram.sv
// ----------------------------------------------------------------------------
// pal_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pal_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule

FILE: sv/positional_address_list.sv
// ----------------------------------------------------------------------------
// positional_address_list
// Bounded ordered list of block addresses held in one RAM; read, insert and
// remove at a position, with the tail shifted one entry per cycle.
// ----------------------------------------------------------------------------
//  channel   ports                             handshake
//  request   req_cmd, req_position, req_addr   taken when start & !busy
//  result    rsp_*                             rsp_valid, one cycle, no stall
//  config    csr_wdata                         written when csr_we
//
// A failed or unknown request answers in the cycle right after it is taken,
// and the next item can follow at once. A read passes through the shift
// state, an appending insert through the put state, a remove walks up from
// the position to the tail, and an insert ahead of other entries walks down
// from the tail to the position and then puts, the RAM read port moving one
// entry per cycle. Reset clears the count and sets block size to 16; the RAM
// itself is not cleared. The result strobe cannot be held off.
// ----------------------------------------------------------------------------
module positional_address_list
   import pal_pkg::*;
#(
   parameter int ADDR_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [CMD_W-1:0]      req_cmd,
   input  logic [POS_W-1:0]      req_position,
   input  logic [ADDR_WIDTH-1:0] req_addr,
   output logic                  rsp_valid,
   output logic [ADDR_WIDTH-1:0] rsp_read_addr,
   output logic [COUNT_W-1:0]    rsp_count,
   output logic                  rsp_is_empty,
   output logic [BSIZE_W-1:0]    rsp_size_of_block,
   output logic [STATUS_W-1:0]   rsp_status,
   input  logic                  csr_we,
   input  logic [BSIZE_W-1:0]    csr_wdata
);

   localparam int DEPTH = LIST_DEPTH;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > POS_W + 1) ? CNT_W : POS_W + 1;

   typedef logic [CMP_W-1:0] cmp_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [BSIZE_W-1:0]    bsize_ff;
   logic [CMD_W-1:0]      cmd_ff, cmd_in;
   logic [IDX_W-1:0]      pos_ff, pos_in;
   logic [ADDR_WIDTH-1:0] addr_ff, addr_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [IDX_W-1:0]      last_ff, last_in;
   logic                  rd_more_ff, rd_more_in;
   logic                  prev_ff, prev_in;
   logic [IDX_W-1:0]      prev_idx_ff, prev_idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ADDR_WIDTH-1:0] rsp_addr_ff, rsp_addr_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;

   logic                  ram_we;
   logic [IDX_W-1:0]      ram_waddr;
   logic [ADDR_WIDTH-1:0] ram_wdata;
   logic                  ram_re;
   logic [IDX_W-1:0]      ram_raddr;
   logic [ADDR_WIDTH-1:0] ram_rdata;

   logic                  accept;
   logic                  acc_shift;
   logic                  acc_put;
   logic [STATUS_W-1:0]   acc_status;
   logic                  shift_up;
   logic                  shift_end;
   cmp_type               pos_c;
   cmp_type               cnt_c;

   pal_ram #(
      .WIDTH (ADDR_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // decode the incoming item against the current count
   always_comb begin
      pos_c      = cmp_type'(req_position);
      cnt_c      = cmp_type'(count_ff);
      accept     = start && !busy;
      acc_shift  = 1'b0;
      acc_put    = 1'b0;
      acc_status = STATUS_OK;
      unique case (req_cmd)
         CMD_READ, CMD_REMOVE: begin
            if (pos_c < cnt_c) begin
               acc_shift = 1'b1;
            end else begin
               acc_status = STATUS_RANGE;
            end
         end
         CMD_INSERT: begin
            if (pos_c > cnt_c) begin
               acc_status = STATUS_RANGE;
            end else if (count_ff == CNT_W'(DEPTH)) begin
               acc_status = STATUS_FULL;
            end else if (pos_c == cnt_c) begin
               acc_put = 1'b1;
            end else begin
               acc_shift = 1'b1;
            end
         end
         default: begin
            acc_status = STATUS_OK;
         end
      endcase
      shift_up  = (cmd_ff == CMD_INSERT);
      shift_end = prev_ff && !rd_more_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && acc_shift) begin
               state_in = ST_SHIFT;
            end else if (accept && acc_put) begin
               state_in = ST_PUT;
            end
         end
         ST_SHIFT: begin
            if (shift_end) begin
               state_in = shift_up ? ST_PUT : ST_IDLE;
            end
         end
         ST_PUT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs, RAM access and datapath updates
   always_comb begin
      count_in      = count_ff;
      cmd_in        = cmd_ff;
      pos_in        = pos_ff;
      addr_in       = addr_ff;
      idx_in        = idx_ff;
      last_in       = last_ff;
      rd_more_in    = rd_more_ff;
      prev_in       = prev_ff;
      prev_idx_in   = prev_idx_ff;
      rsp_valid_in  = 1'b0;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      ram_we        = 1'b0;
      ram_waddr     = pos_ff;
      ram_wdata     = addr_ff;
      ram_re        = 1'b0;
      ram_raddr     = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in      = req_cmd;
               pos_in      = IDX_W'(req_position);
               addr_in     = req_addr;
               rsp_addr_in = '0;
               if (acc_shift) begin
                  rd_more_in = 1'b1;
                  prev_in    = 1'b0;
                  if (req_cmd == CMD_INSERT) begin
                     // walk down from the tail to the insert position
                     idx_in  = IDX_W'(count_ff - 1'b1);
                     last_in = IDX_W'(req_position);
                  end else if (req_cmd == CMD_REMOVE) begin
                     // walk up from the position to the tail
                     idx_in  = IDX_W'(req_position);
                     last_in = IDX_W'(count_ff - 1'b1);
                  end else begin
                     idx_in  = IDX_W'(req_position);
                     last_in = IDX_W'(req_position);
                  end
               end else if (!acc_put) begin
                  // failed or unknown request: answer at once
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = acc_status;
               end
            end
         end
         ST_SHIFT: begin
            // issue the next read of the walk
            ram_re      = rd_more_ff;
            prev_in     = rd_more_ff;
            prev_idx_in = idx_ff;
            if (rd_more_ff) begin
               if (idx_ff == last_ff) begin
                  rd_more_in = 1'b0;
               end else if (shift_up) begin
                  idx_in = IDX_W'(idx_ff - 1'b1);
               end else begin
                  idx_in = IDX_W'(idx_ff + 1'b1);
               end
            end
            // move the entry read last cycle one place over, or capture it as the result
            if (prev_ff) begin
               ram_wdata = ram_rdata;
               if (shift_up) begin
                  ram_we    = 1'b1;
                  ram_waddr = IDX_W'(prev_idx_ff + 1'b1);
               end else if (prev_idx_ff == pos_ff) begin
                  rsp_addr_in = ram_rdata;
               end else if (cmd_ff == CMD_REMOVE) begin
                  ram_we    = 1'b1;
                  ram_waddr = IDX_W'(prev_idx_ff - 1'b1);
               end
            end
            if (shift_end && !shift_up) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               if (cmd_ff == CMD_REMOVE) begin
                  count_in = CNT_W'(count_ff - 1'b1);
               end
            end
         end
         ST_PUT: begin
            // drop the new address into its slot
            ram_we        = 1'b1;
            ram_waddr     = pos_ff;
            ram_wdata     = addr_ff;
            count_in      = CNT_W'(count_ff + 1'b1);
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_OK;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         bsize_ff     <= BSIZE_RESET;
         rd_more_ff   <= 1'b0;
         prev_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_more_ff   <= rd_more_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            bsize_ff <= csr_wdata;
         end
      end
      cmd_ff        <= cmd_in;
      pos_ff        <= pos_in;
      addr_ff       <= addr_in;
      idx_ff        <= idx_in;
      last_ff       <= last_in;
      prev_idx_ff   <= prev_idx_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   // result ports
   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_addr     = rsp_addr_ff;
   assign rsp_count         = COUNT_W'(count_ff);
   assign rsp_is_empty      = (count_ff == '0);
   assign rsp_size_of_block = bsize_ff;
   assign rsp_status        = rsp_status_ff;

endmodule
